### rtl/agc_pkg.sv
// Shared constants and payload types for the affine geotransform converter.
package agc_pkg;

    localparam int FRAC_BITS  = 24;
    localparam int INDEX_BITS = 32;
    localparam int QUO_BITS   = INDEX_BITS + 1;
    localparam int NUM_BITS   = 130;
    localparam int ADDR_BITS  = 6;

    localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [2:0] REG_X_PER_COL = 3'd1;
    localparam logic [2:0] REG_X_PER_ROW = 3'd2;
    localparam logic [2:0] REG_ORIGIN_Y  = 3'd3;
    localparam logic [2:0] REG_Y_PER_COL = 3'd4;
    localparam logic [2:0] REG_Y_PER_ROW = 3'd5;

    localparam logic [QUO_BITS-1:0] IDX_LIM = QUO_BITS'(1) << (INDEX_BITS - 1);
    localparam logic [QUO_BITS-1:0] IDX_MAX = IDX_LIM - QUO_BITS'(1);

    typedef struct packed {
        logic               mode;
        logic signed [63:0] world_x;
        logic signed [63:0] world_y;
        logic signed [31:0] cell_row;
        logic signed [31:0] cell_col;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] row_out;
        logic signed [31:0] col_out;
        logic signed [63:0] x_out;
        logic signed [63:0] y_out;
        logic               error_flag;
    } rsp_t;

endpackage

### rtl/agc_idiv.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned magnitudes.
module agc_idiv
    import agc_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic [NUM_BITS-1:0] num,
    input  logic [NUM_BITS-1:0] den,
    output logic [QUO_BITS-1:0] quo
);

    localparam int WW = NUM_BITS + QUO_BITS;

    logic [NUM_BITS-1:0] rem_reg [QUO_BITS-1];
    logic [NUM_BITS-1:0] den_reg [QUO_BITS-1];
    logic [QUO_BITS-1:0] q_reg   [QUO_BITS];

    for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
        localparam int B = QUO_BITS - 1 - k;
        logic [NUM_BITS-1:0] rem_in;
        logic [NUM_BITS-1:0] den_in;
        logic [QUO_BITS-1:0] q_in;
        logic [WW-1:0]       dsh;
        logic [WW-1:0]       rwide;
        logic                ge;

        if (k == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        assign dsh   = WW'(den_in) << B;
        assign rwide = WW'(rem_in);
        assign ge    = rwide >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k] <= {q_in[QUO_BITS-2:0], ge};
            end
        end

        if (k < QUO_BITS - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? NUM_BITS'(rwide - dsh) : rem_in;
                    den_reg[k] <= den_in;
                end
            end
        end
    end

    assign quo = q_reg[QUO_BITS-1];

endmodule

### rtl/affine_geotransform_convert.sv
// Top level: affine geotransform conversion between cell indices and world points.
// One transfer is accepted every cycle unless the result side stalls; each passes
// through five arithmetic stages, a 33-stage divider with one quotient bit per stage
// and the output register. Mode 0 inverts the transform (row and column truncated
// toward zero); mode 1 gives the world point of the cell center. In mode 0 a zero
// determinant, and in either mode a saturated result, sets error_flag. A stall on
// the result side holds the whole pipeline. Coefficients are written over the APB
// port at byte address 8*i and must only change while no transfer is in flight.
module affine_geotransform_convert
    import agc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  cmd_t                 cmd,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rsp_t                 rsp,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready
);

    typedef struct packed {
        logic        mode;
        logic        big_r;
        logic        big_c;
        logic        neg_r;
        logic        neg_c;
        logic        sn_r;
        logic        sn_c;
        logic        dz;
        logic        nz_r;
        logic        nz_c;
        logic [63:0] x;
        logic [63:0] y;
        logic        exy;
    } side_t;

    typedef struct packed {
        logic [31:0] idx;
        logic        err;
    } lane_t;

    logic signed [63:0] origin_x_reg, x_per_col_reg, x_per_row_reg;
    logic signed [63:0] origin_y_reg, y_per_col_reg, y_per_row_reg;

    logic en;
    logic [4:0]          p_vld_reg;
    logic [QUO_BITS-1:0] line_vld_reg;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg;

    // stage 1
    logic                      p1_mode_reg;
    logic signed [64:0]        p1_dx_reg, p1_dy_reg;
    logic signed [QUO_BITS-1:0] p1_oc_reg, p1_or_reg;

    // stage 2
    logic                p2_mode_reg;
    logic [63:0]         ll_reg [6];
    logic signed [65:0]  lh_reg [6];
    logic signed [64:0]  hl_reg [6];
    logic signed [64:0]  hh_reg [6];

    // stage 3
    logic                       p3_mode_reg;
    logic signed [NUM_BITS-1:0] prod_reg [6];

    // stage 4
    logic                       p4_mode_reg;
    logic signed [NUM_BITS-1:0] p4_v0_reg, p4_v1_reg, p4_det_reg;

    // stage 5
    logic                p5_mode_reg;
    logic [NUM_BITS-1:0] p5_nrm_reg, p5_ncm_reg, p5_dm_reg;
    logic                p5_sn_r_reg, p5_sn_c_reg, p5_sd_reg, p5_dz_reg;
    logic                p5_nz_r_reg, p5_nz_c_reg, p5_exy_reg;
    logic [63:0]         p5_x_reg, p5_y_reg;

    side_t side_next;
    side_t line_reg [QUO_BITS];

    logic [QUO_BITS-1:0] quo_r, quo_c;

    logic signed [63:0] a_op [6];
    logic signed [64:0] b_op [6];

    assign en        = !rsp_valid_reg || !rsp_stall;
    assign cmd_stall = !en;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign pready    = 1'b1;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg  <= '0;
            x_per_col_reg <= 64'(1) << FRAC_BITS;
            x_per_row_reg <= '0;
            origin_y_reg  <= '0;
            y_per_col_reg <= '0;
            y_per_row_reg <= -(64'(1) << FRAC_BITS);
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[5:3])
                REG_ORIGIN_X:  origin_x_reg  <= pwdata;
                REG_X_PER_COL: x_per_col_reg <= pwdata;
                REG_X_PER_ROW: x_per_row_reg <= pwdata;
                REG_ORIGIN_Y:  origin_y_reg  <= pwdata;
                REG_Y_PER_COL: y_per_col_reg <= pwdata;
                REG_Y_PER_ROW: y_per_row_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[5:3])
            REG_ORIGIN_X:  prdata = origin_x_reg;
            REG_X_PER_COL: prdata = x_per_col_reg;
            REG_X_PER_ROW: prdata = x_per_row_reg;
            REG_ORIGIN_Y:  prdata = origin_y_reg;
            REG_Y_PER_COL: prdata = y_per_col_reg;
            REG_Y_PER_ROW: prdata = y_per_row_reg;
            default:       prdata = '0;
        endcase
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg     <= '0;
            line_vld_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_vld_reg     <= {p_vld_reg[3:0], cmd_valid};
            line_vld_reg  <= {line_vld_reg[QUO_BITS-2:0], p_vld_reg[4]};
            rsp_valid_reg <= line_vld_reg[QUO_BITS-1];
        end
    end

    // stage 1: offsets and odd indices (2i+1)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_mode_reg <= cmd.mode;
            p1_dx_reg   <= 65'(cmd.world_x) - 65'(origin_x_reg);
            p1_dy_reg   <= 65'(cmd.world_y) - 65'(origin_y_reg);
            p1_or_reg   <= {$signed(cmd.cell_row[INDEX_BITS-1:0]), 1'b1};
            p1_oc_reg   <= {$signed(cmd.cell_col[INDEX_BITS-1:0]), 1'b1};
        end
    end

    always_comb
    begin
        a_op[0] = p1_mode_reg ? x_per_col_reg : y_per_col_reg;
        b_op[0] = p1_mode_reg ? 65'(p1_oc_reg) : p1_dx_reg;
        a_op[1] = p1_mode_reg ? x_per_row_reg : x_per_col_reg;
        b_op[1] = p1_mode_reg ? 65'(p1_or_reg) : p1_dy_reg;
        a_op[2] = p1_mode_reg ? y_per_col_reg : y_per_row_reg;
        b_op[2] = p1_mode_reg ? 65'(p1_oc_reg) : p1_dx_reg;
        a_op[3] = p1_mode_reg ? y_per_row_reg : x_per_row_reg;
        b_op[3] = p1_mode_reg ? 65'(p1_or_reg) : p1_dy_reg;
        a_op[4] = y_per_col_reg;
        b_op[4] = 65'(x_per_row_reg);
        a_op[5] = x_per_col_reg;
        b_op[5] = 65'(y_per_row_reg);
    end

    // stage 2: 32-bit partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_mode_reg <= p1_mode_reg;
            for (int j = 0; j < 6; j++)
            begin
                ll_reg[j] <= a_op[j][31:0] * b_op[j][31:0];
                lh_reg[j] <= $signed({1'b0, a_op[j][31:0]}) * $signed(b_op[j][64:32]);
                hl_reg[j] <= $signed(a_op[j][63:32]) * $signed({1'b0, b_op[j][31:0]});
                hh_reg[j] <= $signed(a_op[j][63:32]) * $signed(b_op[j][64:32]);
            end
        end
    end

    // stage 3: product sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_mode_reg <= p2_mode_reg;
            for (int j = 0; j < 6; j++)
            begin
                prod_reg[j] <= (NUM_BITS'(hh_reg[j]) << 64)
                             + ((NUM_BITS'(lh_reg[j]) + NUM_BITS'(hl_reg[j])) << 32)
                             + NUM_BITS'(ll_reg[j]);
            end
        end
    end

    // stage 4: numerators and determinant, or doubled centers plus one
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p4_mode_reg <= p3_mode_reg;
            p4_det_reg  <= prod_reg[4] - prod_reg[5];
            if (p3_mode_reg)
            begin
                p4_v0_reg <= (NUM_BITS'(origin_x_reg) <<< 1) + prod_reg[0] + prod_reg[1]
                           + NUM_BITS'(1);
                p4_v1_reg <= (NUM_BITS'(origin_y_reg) <<< 1) + prod_reg[2] + prod_reg[3]
                           + NUM_BITS'(1);
            end
            else
            begin
                p4_v0_reg <= prod_reg[0] - prod_reg[1];
                p4_v1_reg <= prod_reg[2] - prod_reg[3];
            end
        end
    end

    // stage 5: magnitudes, center halving and saturation
    logic signed [NUM_BITS-1:0] hx, hy;
    logic                       fx, fy;

    always_comb
    begin
        hx = p4_v0_reg >>> 1;
        hy = p4_v1_reg >>> 1;
        fx = (hx[NUM_BITS-1:63] == '0) || (hx[NUM_BITS-1:63] == '1);
        fy = (hy[NUM_BITS-1:63] == '0) || (hy[NUM_BITS-1:63] == '1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p5_mode_reg <= p4_mode_reg;
            p5_nrm_reg  <= p4_v0_reg[NUM_BITS-1] ? NUM_BITS'(-p4_v0_reg) : p4_v0_reg;
            p5_ncm_reg  <= p4_v1_reg[NUM_BITS-1] ? NUM_BITS'(-p4_v1_reg) : p4_v1_reg;
            p5_dm_reg   <= p4_det_reg[NUM_BITS-1] ? NUM_BITS'(-p4_det_reg) : p4_det_reg;
            p5_sn_r_reg <= p4_v0_reg[NUM_BITS-1];
            p5_sn_c_reg <= p4_v1_reg[NUM_BITS-1];
            p5_sd_reg   <= p4_det_reg[NUM_BITS-1];
            p5_dz_reg   <= p4_det_reg == '0;
            p5_nz_r_reg <= p4_v0_reg != '0;
            p5_nz_c_reg <= p4_v1_reg != '0;
            p5_x_reg    <= fx ? hx[63:0] : (hx[NUM_BITS-1] ? 64'h8000_0000_0000_0000
                                                           : 64'h7FFF_FFFF_FFFF_FFFF);
            p5_y_reg    <= fy ? hy[63:0] : (hy[NUM_BITS-1] ? 64'h8000_0000_0000_0000
                                                           : 64'h7FFF_FFFF_FFFF_FFFF);
            p5_exy_reg  <= !fx || !fy;
        end
    end

    // quotient range precheck alongside the divider
    always_comb
    begin
        side_next.mode  = p5_mode_reg;
        side_next.big_r = {{QUO_BITS{1'b0}}, p5_nrm_reg} >= {p5_dm_reg, {QUO_BITS{1'b0}}};
        side_next.big_c = {{QUO_BITS{1'b0}}, p5_ncm_reg} >= {p5_dm_reg, {QUO_BITS{1'b0}}};
        side_next.neg_r = p5_sn_r_reg ^ p5_sd_reg;
        side_next.neg_c = p5_sn_c_reg ^ !p5_sd_reg;
        side_next.sn_r  = p5_sn_r_reg;
        side_next.sn_c  = p5_sn_c_reg;
        side_next.dz    = p5_dz_reg;
        side_next.nz_r  = p5_nz_r_reg;
        side_next.nz_c  = p5_nz_c_reg;
        side_next.x     = p5_x_reg;
        side_next.y     = p5_y_reg;
        side_next.exy   = p5_exy_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= side_next;
            for (int k = 1; k < QUO_BITS; k++)
            begin
                line_reg[k] <= line_reg[k-1];
            end
        end
    end

    agc_idiv u_div_row (
        .clk (clk),
        .en  (en),
        .num (p5_nrm_reg),
        .den (p5_dm_reg),
        .quo (quo_r)
    );

    agc_idiv u_div_col (
        .clk (clk),
        .en  (en),
        .num (p5_ncm_reg),
        .den (p5_dm_reg),
        .quo (quo_c)
    );

    function automatic lane_t lane_fix(input logic [QUO_BITS-1:0] q, input logic big,
                                       input logic neg, input logic dz, input logic nz,
                                       input logic sn);
        lane_t               r;
        logic [QUO_BITS-1:0] cap;
        logic [QUO_BITS-1:0] mag;
        logic [QUO_BITS-1:0] sv;
        cap = neg ? IDX_LIM : IDX_MAX;
        mag = '0;
        if (dz)
        begin
            r.err = 1'b1;
            sv    = !nz ? '0 : (sn ? -IDX_LIM : IDX_MAX);
        end
        else
        begin
            r.err = big || (q > cap);
            mag   = r.err ? cap : q;
            sv    = neg ? -mag : mag;
        end
        r.idx = 32'($signed(sv[INDEX_BITS-1:0]));
        return r;
    endfunction

    side_t tail;
    lane_t lr, lc;
    rsp_t  rsp_next;

    always_comb
    begin
        tail = line_reg[QUO_BITS-1];
        lr   = lane_fix(quo_r, tail.big_r, tail.neg_r, tail.dz, tail.nz_r, tail.sn_r);
        lc   = lane_fix(quo_c, tail.big_c, tail.neg_c, tail.dz, tail.nz_c, tail.sn_c);
        if (tail.mode)
        begin
            rsp_next.row_out    = '0;
            rsp_next.col_out    = '0;
            rsp_next.x_out      = tail.x;
            rsp_next.y_out      = tail.y;
            rsp_next.error_flag = tail.exy;
        end
        else
        begin
            rsp_next.row_out    = lr.idx;
            rsp_next.col_out    = lc.idx;
            rsp_next.x_out      = '0;
            rsp_next.y_out      = '0;
            rsp_next.error_flag = lr.err || lc.err;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // a held result freezes every stage
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> $stable({p_vld_reg, line_vld_reg}))
        else $error("pipeline moved while result held");

    // world and cell fields never both carry data
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.x_out != '0 || rsp.y_out != '0))
        |-> (rsp.row_out == '0 && rsp.col_out == '0))
        else $error("mixed result fields");

endmodule

### tb/tb_affine_geotransform_convert.sv
// Testbench for the affine geotransform converter: directed and random transfers.
module tb_affine_geotransform_convert;
    import agc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 400000;
    localparam int LATENCY = 45;

    typedef logic signed [191:0] wide_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cmd_valid;
    logic                 cmd_stall;
    cmd_t                 cmd;
    logic                 rsp_valid;
    logic                 rsp_stall;
    rsp_t                 rsp;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [63:0]          pwdata;
    logic [63:0]          prdata;
    logic                 pready;

    logic signed [63:0] geo [6];
    rsp_t               expected_rsp [$];
    int                 errors;
    int                 cycles;
    int                 tx_pct;
    int                 rx_pct;
    int                 hold_left;

    affine_geotransform_convert u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd      (cmd),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic wide_t sx(logic signed [63:0] v);
        return 192'(v);
    endfunction

    function automatic logic [31:0] index_quot(wide_t n, wide_t d, inout logic err);
        wide_t q;
        if (d == 0)
        begin
            err = 1'b1;
            if (n == 0)
                return 32'h0;
            return (n < 0) ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        q = n / d;
        if (q > sx(64'sh7fff_ffff))
        begin
            err = 1'b1;
            return 32'h7fff_ffff;
        end
        if (q < sx(-64'sh8000_0000))
        begin
            err = 1'b1;
            return 32'h8000_0000;
        end
        return q[31:0];
    endfunction

    function automatic logic [63:0] cell_center(logic signed [63:0] org,
        logic signed [63:0] per_col, logic signed [63:0] per_row,
        wide_t odd_col, wide_t odd_row, inout logic err);
        wide_t s;
        s = 2 * sx(org) + sx(per_col) * odd_col + sx(per_row) * odd_row;
        s = (s + 1) >>> 1;
        if (s > sx(64'sh7fff_ffff_ffff_ffff))
        begin
            err = 1'b1;
            return 64'h7fff_ffff_ffff_ffff;
        end
        if (s < sx(64'sh8000_0000_0000_0000))
        begin
            err = 1'b1;
            return 64'h8000_0000_0000_0000;
        end
        return s[63:0];
    endfunction

    function automatic rsp_t convert(cmd_t c);
        wide_t dx, dy, det, nr, nc, odd_row, odd_col;
        rsp_t  r;
        logic  err;
        r = '0;
        err = 1'b0;
        if (!c.mode)
        begin
            dx = sx(c.world_x) - sx(geo[REG_ORIGIN_X]);
            dy = sx(c.world_y) - sx(geo[REG_ORIGIN_Y]);
            det = sx(geo[REG_Y_PER_COL]) * sx(geo[REG_X_PER_ROW])
                - sx(geo[REG_X_PER_COL]) * sx(geo[REG_Y_PER_ROW]);
            nr = sx(geo[REG_Y_PER_COL]) * dx - sx(geo[REG_X_PER_COL]) * dy;
            nc = sx(geo[REG_Y_PER_ROW]) * dx - sx(geo[REG_X_PER_ROW]) * dy;
            r.row_out = index_quot(nr, det, err);
            r.col_out = index_quot(nc, -det, err);
        end
        else
        begin
            odd_row = 2 * sx(64'(c.cell_row)) + 1;
            odd_col = 2 * sx(64'(c.cell_col)) + 1;
            r.x_out = cell_center(geo[REG_ORIGIN_X], geo[REG_X_PER_COL],
                                  geo[REG_X_PER_ROW], odd_col, odd_row, err);
            r.y_out = cell_center(geo[REG_ORIGIN_Y], geo[REG_Y_PER_COL],
                                  geo[REG_Y_PER_ROW], odd_col, odd_row, err);
        end
        r.error_flag = err;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic drain();
        cmd_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic geo_write(logic [2:0] idx, logic [63:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'({idx, 3'b000});
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        geo[idx] = v;
    endtask

    task automatic set_geo(logic [63:0] ox, logic [63:0] a, logic [63:0] b,
                           logic [63:0] oy, logic [63:0] c, logic [63:0] e);
        drain();
        geo_write(REG_ORIGIN_X, ox);
        geo_write(REG_X_PER_COL, a);
        geo_write(REG_X_PER_ROW, b);
        geo_write(REG_ORIGIN_Y, oy);
        geo_write(REG_Y_PER_COL, c);
        geo_write(REG_Y_PER_ROW, e);
    endtask

    task automatic send_cmd(cmd_t c);
        if (tx_pct != 0 && $urandom_range(99) < tx_pct)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do @(posedge clk); while (cmd_stall);
        expected_rsp.push_back(convert(c));
    endtask

    function automatic cmd_t mk(logic m, logic [63:0] wx, logic [63:0] wy,
                                logic [31:0] r, logic [31:0] c);
        cmd_t t;
        t.mode = m;
        t.world_x = wx;
        t.world_y = wy;
        t.cell_row = r;
        t.cell_col = c;
        return t;
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t t;
        int   r, c;
        t = mk(1'($urandom_range(1)), rand64(), rand64(), $urandom, $urandom);
        if ($urandom_range(9) < 7)
        begin
            r = $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
            c = $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
            if (t.mode)
            begin
                t.cell_row = r;
                t.cell_col = c;
            end
            else
            begin
                t.world_x = geo[REG_ORIGIN_X] + geo[REG_X_PER_COL] * c
                          + geo[REG_X_PER_ROW] * r + $signed(64'($urandom_range(0, 2 ** 24)));
                t.world_y = geo[REG_ORIGIN_Y] + geo[REG_Y_PER_COL] * c
                          + geo[REG_Y_PER_ROW] * r - $signed(64'($urandom_range(0, 2 ** 24)));
            end
        end
        return t;
    endfunction

    task automatic random_geo();
        logic [63:0] v [6];
        int          kind;
        kind = $urandom_range(5);
        for (int i = 0; i < 6; i++)
            v[i] = rand64();
        if (kind < 3)
        begin
            v[0] = $signed(rand64()) >>> 14;
            v[3] = $signed(rand64()) >>> 14;
            v[1] = $signed(64'($urandom_range(1, 2 ** 30)));
            v[5] = -$signed(64'($urandom_range(1, 2 ** 30)));
            v[2] = (kind == 0) ? 64'h0 : $signed(64'($urandom)) >>> $urandom_range(8, 31);
            v[4] = (kind == 0) ? 64'h0 : $signed(64'($urandom)) >>> $urandom_range(8, 31);
        end
        else if (kind == 3)
        begin
            v[2] = 64'h0;
            v[4] = 64'h0;
            v[1] = $urandom_range(1) ? 64'h0 : v[1];
            v[5] = (v[1] == 0) ? v[5] : 64'h0;
        end
        set_geo(v[0], v[1], v[2], v[3], v[4], v[5]);
    endtask

    task automatic test_default_geo();
        send_cmd(mk(1'b0, 64'sd92274688, -64'sd54525952, 0, 0));
        send_cmd(mk(1'b0, -64'sd92274688, 64'sd54525952, 0, 0));
        send_cmd(mk(1'b0, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 0, 0));
        send_cmd(mk(1'b0, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, 0, 0));
        send_cmd(mk(1'b0, 64'h0, 64'h0, 32'hffff_ffff, 32'hffff_ffff));
        send_cmd(mk(1'b1, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 0, 0));
        send_cmd(mk(1'b1, 0, 0, 32'h7fff_ffff, 32'h8000_0000));
        send_cmd(mk(1'b1, 0, 0, 32'h8000_0000, 32'h7fff_ffff));
        send_cmd(mk(1'b1, 0, 0, 32'hffff_ffff, 32'd3));
    endtask

    task automatic test_special_cases();
        // zero determinant
        set_geo(0, 0, 0, 0, 0, 0);
        send_cmd(mk(1'b0, 64'd5, 64'd7, 0, 0));
        set_geo(64'd100, 64'sd16777216, 64'sd33554432, 0, 64'sd16777216, 64'sd33554432);
        send_cmd(mk(1'b0, 64'sd500000000, 64'sd3, 0, 0));
        send_cmd(mk(1'b0, -64'sd500000000, 64'sd3, 0, 0));
        send_cmd(mk(1'b0, 64'd100, 64'd0, 0, 0));
        // tiny determinant forces index saturation
        set_geo(0, 64'd1, 0, 0, 0, -64'sd1);
        send_cmd(mk(1'b0, 64'h0000_0001_0000_0000, 64'h8000_0000_0000_0000, 0, 0));
        send_cmd(mk(1'b0, 64'd12345, -64'sd678, 0, 0));
        // extreme coefficients: center overflow both ways
        set_geo(64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff,
                64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        send_cmd(mk(1'b1, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff));
        send_cmd(mk(1'b1, 0, 0, 32'hffff_ffff, 32'h0));
        send_cmd(mk(1'b1, 0, 0, 32'h8000_0000, 32'h8000_0000));
        send_cmd(mk(1'b0, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 0, 0));
        set_geo(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff,
                64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000);
        send_cmd(mk(1'b0, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 0, 0));
        send_cmd(mk(1'b0, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, 0, 0));
        send_cmd(mk(1'b1, 0, 0, 32'hffff_ffff, 32'hffff_ffff));
        send_cmd(mk(1'b1, 0, 0, 32'h7fff_ffff, 32'h8000_0000));
    endtask

    task automatic test_random_phases();
        int tx_set [4] = '{0, 62, 0, 20};
        int rx_set [4] = '{0, 0, 62, 20};
        for (int p = 0; p < 4; p++)
        begin
            random_geo();
            tx_pct = tx_set[p];
            rx_pct = rx_set[p];
            for (int i = 0; i < 170; i++)
            begin
                if (i == 85)
                    random_geo();
                send_cmd(random_cmd());
            end
        end
    endtask

    task automatic test_backpressure();
        set_geo(64'sd1000000, 64'sd16777216, 64'sd65536, -64'sd2000000, -64'sd32768,
                -64'sd16777216);
        tx_pct = 0;
        rx_pct = 0;
        hold_left = 300;
        for (int i = 0; i < 60; i++)
            send_cmd(random_cmd());
        cmd_valid <= 1'b0;
        drain();
        rx_pct = 30;
        for (int i = 0; i < 20; i++)
            send_cmd(random_cmd());
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= (rx_pct != 0) && ($urandom_range(99) < rx_pct);
    end

    always @(posedge clk)
    begin
        rsp_t e;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
            begin
                $error("unexpected result transfer");
                errors++;
            end
            else
            begin
                e = expected_rsp.pop_front();
                if (rsp.row_out !== e.row_out)
                begin
                    $error("row_out expected %0d actual %0d", e.row_out, rsp.row_out);
                    errors++;
                end
                if (rsp.col_out !== e.col_out)
                begin
                    $error("col_out expected %0d actual %0d", e.col_out, rsp.col_out);
                    errors++;
                end
                if (rsp.x_out !== e.x_out)
                begin
                    $error("x_out expected %0d actual %0d", e.x_out, rsp.x_out);
                    errors++;
                end
                if (rsp.y_out !== e.y_out)
                begin
                    $error("y_out expected %0d actual %0d", e.y_out, rsp.y_out);
                    errors++;
                end
                if (rsp.error_flag !== e.error_flag)
                begin
                    $error("error_flag expected %0b actual %0b", e.error_flag,
                           rsp.error_flag);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        errors    = 0;
        cycles    = 0;
        tx_pct    = 0;
        rx_pct    = 0;
        hold_left = 0;
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        geo[REG_ORIGIN_X]  = 64'sd0;
        geo[REG_X_PER_COL] = 64'sd16777216;
        geo[REG_X_PER_ROW] = 64'sd0;
        geo[REG_ORIGIN_Y]  = 64'sd0;
        geo[REG_Y_PER_COL] = 64'sd0;
        geo[REG_Y_PER_ROW] = -64'sd16777216;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_geo();
        test_special_cases();
        test_random_phases();
        test_backpressure();
        cmd_valid <= 1'b0;
        drain();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
